// ===== hw/rtl/cmfta_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfta_pkg: shared types and constants for cube map texel addressing
// Field widths, pipeline payload structs, axis codes and the per-face tables.
// ----------------------------------------------------------------------------
package cmfta_pkg;

   // direction and face size limits
   localparam int DIR_WIDTH    = 16;
   localparam int MAX_FACE_DIM = 4096;

   // fixed field widths
   localparam int CFG_W  = 13;
   localparam int TEX_W  = 12;
   localparam int FACE_W = 3;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // derived datapath widths
   localparam int DIM_W  = $clog2(MAX_FACE_DIM + 1);
   localparam int MAG_W  = DIR_WIDTH;
   localparam int SGN_W  = DIR_WIDTH + 1;
   localparam int NUM_W  = DIR_WIDTH + 1;
   localparam int PROD_W = DIM_W + NUM_W;
   localparam int QUO_W  = DIM_W;

   // register index codes (address bit 2)
   localparam logic REG_FACE_WIDTH  = 1'b0;
   localparam logic REG_FACE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] FACE_DIM_RESET = CFG_W'(512);

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic signed [DIR_WIDTH-1:0] dir_x;
      logic signed [DIR_WIDTH-1:0] dir_y;
      logic signed [DIR_WIDTH-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [TEX_W-1:0]  texel_x;
      logic [TEX_W-1:0]  texel_y;
      logic              valid_res;
   } rsp_type;

   // after major axis selection
   typedef struct packed {
      axis_type                ax;
      logic                    pos;
      logic [MAG_W-1:0]        d;
      logic signed [SGN_W-1:0] nu;
      logic signed [SGN_W-1:0] nv;
   } axis_sel_type;

   // numerators over the common denominator 2d
   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic              zero;
      logic [NUM_W-1:0]  den;
      logic [NUM_W-1:0]  u_num;
      logic [NUM_W-1:0]  v_num;
   } numer_type;

   // divider chain payload
   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic              zero;
      logic [NUM_W-1:0]  den;
      logic [PROD_W-1:0] rem_u;
      logic [PROD_W-1:0] rem_v;
      logic [QUO_W-1:0]  q_u;
      logic [QUO_W-1:0]  q_v;
   } div_type;

   // minor axis carried by u for each major axis
   function automatic axis_type u_axis_of(axis_type ax);
      case (ax)
         AXIS_X:  u_axis_of = AXIS_Z;
         AXIS_Y:  u_axis_of = AXIS_X;
         AXIS_Z:  u_axis_of = AXIS_X;
         default: u_axis_of = AXIS_X;
      endcase
   endfunction

   // minor axis carried by v for each major axis
   function automatic axis_type v_axis_of(axis_type ax);
      case (ax)
         AXIS_X:  v_axis_of = AXIS_Y;
         AXIS_Y:  v_axis_of = AXIS_Z;
         AXIS_Z:  v_axis_of = AXIS_Y;
         default: v_axis_of = AXIS_Y;
      endcase
   endfunction

   // u mirrored on +x and on -z faces
   function automatic logic flip_u(axis_type ax, logic pos);
      case (ax)
         AXIS_X:  flip_u = pos;
         AXIS_Y:  flip_u = 1'b0;
         AXIS_Z:  flip_u = !pos;
         default: flip_u = 1'b0;
      endcase
   endfunction

   // v mirrored on every face but +y
   function automatic logic flip_v(axis_type ax, logic pos);
      case (ax)
         AXIS_Y:  flip_v = !pos;
         default: flip_v = 1'b1;
      endcase
   endfunction

   // effective face size: zero reads as one, oversize saturates
   function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_W-1:0] r);
      if (r == '0) begin
         eff_dim = DIM_W'(1);
      end else if (32'(r) > 32'(MAX_FACE_DIM)) begin
         eff_dim = DIM_W'(MAX_FACE_DIM);
      end else begin
         eff_dim = DIM_W'(r);
      end
   endfunction

endpackage

// ===== hw/rtl/cmfta_front.sv =====
// ----------------------------------------------------------------------------
// cmfta_front: major axis selection and coordinate numerators
// Two registered stages: mirror, magnitudes and axis pick, then numerators
// with the per-face flips.
// ----------------------------------------------------------------------------
module cmfta_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  cmfta_pkg::req_type up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output cmfta_pkg::numer_type dn_data
);
   import cmfta_pkg::*;

   logic signed [SGN_W-1:0] m_x, m_y, m_z;
   logic [MAG_W-1:0]        mag_x, mag_y, mag_z;
   logic signed [SGN_W-1:0] m_sel;
   logic [MAG_W-1:0]        d_sel;
   axis_type                ax_sel;

   axis_sel_type a_in, a_ff;
   logic         a_vld_ff, a_ready;
   numer_type    b_in, b_ff;
   logic         b_vld_ff, b_ready;
   logic [NUM_W-1:0] dd;

   function automatic logic signed [SGN_W-1:0] pick_m(axis_type ax,
         logic signed [SGN_W-1:0] px, logic signed [SGN_W-1:0] py,
         logic signed [SGN_W-1:0] pz);
      case (ax)
         AXIS_X:  pick_m = px;
         AXIS_Y:  pick_m = py;
         AXIS_Z:  pick_m = pz;
         default: pick_m = px;
      endcase
   endfunction

   // mirror x and take magnitudes
   assign m_x = -{up_data.dir_x[DIR_WIDTH-1], up_data.dir_x};
   assign m_y = {up_data.dir_y[DIR_WIDTH-1], up_data.dir_y};
   assign m_z = {up_data.dir_z[DIR_WIDTH-1], up_data.dir_z};
   assign mag_x = MAG_W'(m_x[SGN_W-1] ? -m_x : m_x);
   assign mag_y = MAG_W'(m_y[SGN_W-1] ? -m_y : m_y);
   assign mag_z = MAG_W'(m_z[SGN_W-1] ? -m_z : m_z);

   // largest magnitude, ties to the lower axis
   always_comb begin
      ax_sel = AXIS_X;
      d_sel  = mag_x;
      m_sel  = m_x;
      if (mag_y > d_sel) begin
         ax_sel = AXIS_Y;
         d_sel  = mag_y;
         m_sel  = m_y;
      end
      if (mag_z > d_sel) begin
         ax_sel = AXIS_Z;
         d_sel  = mag_z;
         m_sel  = m_z;
      end
      a_in.ax  = ax_sel;
      a_in.d   = d_sel;
      a_in.pos = !m_sel[SGN_W-1] && (m_sel != '0);
      a_in.nu  = pick_m(u_axis_of(ax_sel), m_x, m_y, m_z);
      a_in.nv  = pick_m(v_axis_of(ax_sel), m_x, m_y, m_z);
   end

   // stage a handshake
   assign a_ready = !a_vld_ff || b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_ready) begin
         a_vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && a_ready) begin
         a_ff <= a_in;
      end
   end

   // numerators d +/- n, flipped form is 2d - (n + d) = d - n
   assign dd = NUM_W'(a_ff.d);

   always_comb begin
      b_in.face  = {a_ff.ax, !a_ff.pos};
      b_in.zero  = (a_ff.d == '0);
      b_in.den   = {a_ff.d, 1'b0};
      b_in.u_num = flip_u(a_ff.ax, a_ff.pos) ? dd - NUM_W'(a_ff.nu) : dd + NUM_W'(a_ff.nu);
      b_in.v_num = flip_v(a_ff.ax, a_ff.pos) ? dd - NUM_W'(a_ff.nv) : dd + NUM_W'(a_ff.nv);
   end

   // stage b handshake
   assign b_ready = !b_vld_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_ready) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_vld_ff && b_ready) begin
         b_ff <= b_in;
      end
   end

   assign up_ready = a_ready;
   assign dn_valid = b_vld_ff;
   assign dn_data  = b_ff;

endmodule

// ===== hw/rtl/cmfta_mul.sv =====
// ----------------------------------------------------------------------------
// cmfta_mul: face size scaling
// Multiplies both numerators by the face width and height and loads the
// divider chain payload.
// ----------------------------------------------------------------------------
module cmfta_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [cmfta_pkg::DIM_W-1:0] dim_w,
   input  logic [cmfta_pkg::DIM_W-1:0] dim_h,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  cmfta_pkg::numer_type       up_data,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output cmfta_pkg::div_type         dn_data
);
   import cmfta_pkg::*;

   div_type data_in, data_ff;
   logic    vld_ff;

   // products start as the dividends
   always_comb begin
      data_in.face  = up_data.face;
      data_in.zero  = up_data.zero;
      data_in.den   = up_data.den;
      data_in.rem_u = PROD_W'(dim_w) * PROD_W'(up_data.u_num);
      data_in.rem_v = PROD_W'(dim_h) * PROD_W'(up_data.v_num);
      data_in.q_u   = '0;
      data_in.q_v   = '0;
   end

   assign up_ready = !vld_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

endmodule

// ===== hw/rtl/cmfta_div_cell.sv =====
// ----------------------------------------------------------------------------
// cmfta_div_cell: one restoring division step
// Settles one quotient bit for both coordinates and hands the shifted
// remainders to the next cell.
// ----------------------------------------------------------------------------
module cmfta_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  cmfta_pkg::div_type up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output cmfta_pkg::div_type dn_data
);
   import cmfta_pkg::*;

   logic [PROD_W-2:0] den_sh;
   logic [PROD_W:0]   diff_u, diff_v;
   logic              ge_u, ge_v;
   logic [PROD_W-1:0] rnext_u, rnext_v;
   div_type           data_in, data_ff;
   logic              vld_ff;

   // divisor aligned to the top quotient bit
   assign den_sh = {up_data.den, (QUO_W-1)'(0)};

   // trial subtract, borrow means the bit is zero
   assign diff_u  = {1'b0, up_data.rem_u} - {2'b00, den_sh};
   assign diff_v  = {1'b0, up_data.rem_v} - {2'b00, den_sh};
   assign ge_u    = !diff_u[PROD_W];
   assign ge_v    = !diff_v[PROD_W];
   assign rnext_u = ge_u ? diff_u[PROD_W-1:0] : up_data.rem_u;
   assign rnext_v = ge_v ? diff_v[PROD_W-1:0] : up_data.rem_v;

   always_comb begin
      data_in       = up_data;
      data_in.rem_u = {rnext_u[PROD_W-2:0], 1'b0};
      data_in.rem_v = {rnext_v[PROD_W-2:0], 1'b0};
      data_in.q_u   = {up_data.q_u[QUO_W-2:0], ge_u};
      data_in.q_v   = {up_data.q_v[QUO_W-2:0], ge_v};
   end

   assign up_ready = !vld_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

endmodule

// ===== hw/rtl/cmfta_out.sv =====
// ----------------------------------------------------------------------------
// cmfta_out: clamp and result register
// Clamps the quotients into the face, handles the zero vector and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module cmfta_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [cmfta_pkg::DIM_W-1:0] dim_w,
   input  logic [cmfta_pkg::DIM_W-1:0] dim_h,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  cmfta_pkg::div_type         up_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cmfta_pkg::rsp_type         rsp_data
);
   import cmfta_pkg::*;

   logic [QUO_W-1:0] tx, ty;
   rsp_type          data_in, data_ff;
   logic             vld_ff;

   // a coordinate of one lands on the last texel
   assign tx = (up_data.q_u >= dim_w) ? dim_w - 1'b1 : up_data.q_u;
   assign ty = (up_data.q_v >= dim_h) ? dim_h - 1'b1 : up_data.q_v;

   always_comb begin
      if (up_data.zero) begin
         data_in = '0;
      end else begin
         data_in.face      = up_data.face;
         data_in.texel_x   = TEX_W'(tx);
         data_in.texel_y   = TEX_W'(ty);
         data_in.valid_res = 1'b1;
      end
   end

   assign up_ready = !vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/cubemap_face_texel_address_top.sv =====
// ----------------------------------------------------------------------------
// cubemap_face_texel_address_top: cube map face and texel address
// Direction vector in, face index and clamped texel coordinates out.
// ----------------------------------------------------------------------------
// The block takes one direction item per clock while its stages are not
// stalled, and returns one result item per item, in order. An item passes
// through two decode stages, one multiply stage, a chain of QUO_W division
// cells that each settle one quotient bit of both texel coordinates, and
// the output register. Every stage holds its own item, so bubbles close up
// behind a stalled output. Face width and height are to be written through
// the APB port at byte addresses 0 and 4 only while no item is in flight;
// the block itself does not enforce this. A size of zero acts as one and
// sizes above the maximum saturate.
module cubemap_face_texel_address_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cmfta_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cmfta_pkg::rsp_type                   rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cmfta_pkg::ADDR_W-1:0]         paddr,
   input  logic [cmfta_pkg::DATA_W-1:0]         pwdata,
   output logic [cmfta_pkg::DATA_W-1:0]         prdata,
   output logic                                 pready
);
   import cmfta_pkg::*;

   logic [CFG_W-1:0] face_width_ff, face_height_ff;
   logic [DIM_W-1:0] dim_w, dim_h;
   logic             csr_write;

   numer_type        numer_data;
   logic             numer_valid, numer_ready;
   div_type          div_data [QUO_W+1];
   logic [QUO_W:0]   div_valid, div_ready;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff  <= FACE_DIM_RESET;
         face_height_ff <= FACE_DIM_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_FACE_HEIGHT) begin
            face_height_ff <= pwdata[CFG_W-1:0];
         end else begin
            face_width_ff <= pwdata[CFG_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_FACE_WIDTH) ? DATA_W'(face_width_ff)
                                                : DATA_W'(face_height_ff);

   assign dim_w = eff_dim(face_width_ff);
   assign dim_h = eff_dim(face_height_ff);

   // axis pick and numerators
   cmfta_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .dn_valid (numer_valid),
      .dn_ready (numer_ready),
      .dn_data  (numer_data)
   );

   // scale by face size
   cmfta_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .dim_w    (dim_w),
      .dim_h    (dim_h),
      .up_valid (numer_valid),
      .up_ready (numer_ready),
      .up_data  (numer_data),
      .dn_valid (div_valid[0]),
      .dn_ready (div_ready[0]),
      .dn_data  (div_data[0])
   );

   // division chain, one quotient bit per cell
   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      cmfta_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[k]),
         .up_ready (div_ready[k]),
         .up_data  (div_data[k]),
         .dn_valid (div_valid[k+1]),
         .dn_ready (div_ready[k+1]),
         .dn_data  (div_data[k+1])
      );
   end

   // clamp and result register
   cmfta_out u_out (
      .clock     (clock),
      .reset     (reset),
      .dim_w     (dim_w),
      .dim_h     (dim_h),
      .up_valid  (div_valid[QUO_W]),
      .up_ready  (div_ready[QUO_W]),
      .up_data   (div_data[QUO_W]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/cmfta_checker.sv =====
// ----------------------------------------------------------------------------
// cmfta_checker: port level checks for the texel address block
// Watches the result channel of the top level; bound to it below.
// ----------------------------------------------------------------------------
module cmfta_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input cmfta_pkg::rsp_type rsp_data
);
   import cmfta_pkg::*;

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // zero vector gives an all zero item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |->
         rsp_data.face == '0 && rsp_data.texel_x == '0 && rsp_data.texel_y == '0)
      else $error("zero vector item carries nonzero fields");

   // only six faces exist
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.face <= FACE_W'(5))
      else $error("face index out of range");

   // pipeline is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

endmodule

bind cubemap_face_texel_address_top cmfta_checker u_cmfta_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_cubemap_face_texel_address_top.sv =====
// ----------------------------------------------------------------------------
// tb_cubemap_face_texel_address_top: regression for cube map texel addressing
// Drives direction items through the valid/ready input, predicts face and
// texel per item for the programmed face size and checks every result in
// order. Face sizes are reprogrammed between phases over the apb port.
// ----------------------------------------------------------------------------
module tb_cubemap_face_texel_address_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cmfta_pkg::*;

   localparam int LATENCY      = QUO_W + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 85;
   localparam int IDLE_PCT     = 38;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 400;

   // face indexes as reported on the result
   localparam logic [FACE_W-1:0] FACE_NONE  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   // face sizes per phase after the reset phase
   localparam int PHASE_W [6] = '{1, 4096, 0, 8191, 4095, 7};
   localparam int PHASE_H [6] = '{1, 4096, 0, 4097, 1, 3000};

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   typedef struct {
      req_type dir;
      bit      typed;
      rsp_type want;
   } dir_case_type;

   dir_case_type     directed_cases[$];
   rsp_type          pending_texels[$];
   logic [CFG_W-1:0] width_reg  = FACE_DIM_RESET;
   logic [CFG_W-1:0] height_reg = FACE_DIM_RESET;
   int               mismatch_count = 0;
   int               results_seen   = 0;
   int               cycle_count    = 0;
   int               hold_left      = 0;
   bit               hold_done      = 1'b0;
   bit               no_idle        = 1'b0;

   cubemap_face_texel_address_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(string what, longint want, longint got);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   // floor of size * num / den, clamped into the face
   function automatic logic [TEX_W-1:0] scaled_texel(logic [CFG_W-1:0] size_reg,
                                                     longint num, longint den);
      longint dim;
      longint t;
      if (size_reg == '0) begin
         dim = 1;
      end else if (longint'(size_reg) > MAX_FACE_DIM) begin
         dim = MAX_FACE_DIM;
      end else begin
         dim = longint'(size_reg);
      end
      t = (dim * num) / den;
      if (t > dim - 1) begin
         t = dim - 1;
      end
      return TEX_W'(t);
   endfunction

   // face and texel for one direction at the given face size
   function automatic rsp_type texel_address_of(req_type dir, logic [CFG_W-1:0] w_reg,
                                                logic [CFG_W-1:0] h_reg);
      longint   m [3];
      longint   mag [3];
      longint   d;
      longint   den;
      longint   u_num;
      longint   v_num;
      axis_type ax;
      logic     pos;
      rsp_type  r;
      // x is mirrored before anything else
      m[AXIS_X] = -longint'($signed(dir.dir_x));
      m[AXIS_Y] = longint'($signed(dir.dir_y));
      m[AXIS_Z] = longint'($signed(dir.dir_z));
      for (int i = 0; i < 3; i++) begin
         mag[i] = (m[i] < 0) ? -m[i] : m[i];
      end
      // ties keep the lower axis
      ax = AXIS_X;
      if (mag[AXIS_Y] > mag[ax]) begin
         ax = AXIS_Y;
      end
      if (mag[AXIS_Z] > mag[ax]) begin
         ax = AXIS_Z;
      end
      r = '0;
      d = mag[ax];
      if (d == 0) begin
         return r;
      end
      pos = (m[ax] > 0);
      den = 2 * d;
      // minor coordinates over 2d with per-face flips
      case (ax)
         AXIS_X: begin
            u_num = m[AXIS_Z] + d;
            v_num = m[AXIS_Y] + d;
            if (pos) u_num = den - u_num;
         end
         AXIS_Y: begin
            u_num = m[AXIS_X] + d;
            v_num = m[AXIS_Z] + d;
            if (!pos) v_num = den - v_num;
         end
         default: begin
            u_num = m[AXIS_X] + d;
            v_num = m[AXIS_Y] + d;
            if (!pos) u_num = den - u_num;
         end
      endcase
      if (ax != AXIS_Y) begin
         v_num = den - v_num;
      end
      r.face      = FACE_W'(2 * int'(ax) + (pos ? 0 : 1));
      r.texel_x   = scaled_texel(w_reg, u_num, den);
      r.texel_y   = scaled_texel(h_reg, v_num, den);
      r.valid_res = 1'b1;
      return r;
   endfunction

   function automatic logic [DIR_WIDTH-1:0] signed_mag(int mag);
      return DIR_WIDTH'(($urandom_range(0, 1) != 0) ? -mag : mag);
   endfunction

   function automatic logic [DIR_WIDTH-1:0] corner_dir();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h8001;
         2:       return 16'hffff;
         3:       return 16'h0000;
         4:       return 16'h0001;
         default: return 16'h7fff;
      endcase
   endfunction

   function automatic req_type random_dir();
      req_type r;
      int      kind;
      int      big;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         // full range, every bit pattern
         r.dir_x = DIR_WIDTH'($urandom);
         r.dir_y = DIR_WIDTH'($urandom);
         r.dir_z = DIR_WIDTH'($urandom);
      end else if (kind < 5) begin
         // tiny components: ties and zero vectors
         r.dir_x = signed_mag($urandom_range(0, 3));
         r.dir_y = signed_mag($urandom_range(0, 3));
         r.dir_z = signed_mag($urandom_range(0, 3));
      end else if (kind < 8) begin
         // one dominant axis
         big = $urandom_range(1, 32767);
         r.dir_x = signed_mag($urandom_range(0, big));
         r.dir_y = signed_mag($urandom_range(0, big));
         r.dir_z = signed_mag($urandom_range(0, big));
         case ($urandom_range(0, 2))
            0:       r.dir_x = signed_mag(big);
            1:       r.dir_y = signed_mag(big);
            default: r.dir_z = signed_mag(big);
         endcase
      end else if (kind == 8) begin
         // equal magnitudes on some subset of axes
         big = $urandom_range(1, 32767);
         r.dir_x = ($urandom_range(0, 1) != 0) ? signed_mag(big)
                                               : signed_mag($urandom_range(0, big));
         r.dir_y = ($urandom_range(0, 1) != 0) ? signed_mag(big)
                                               : signed_mag($urandom_range(0, big));
         r.dir_z = ($urandom_range(0, 1) != 0) ? signed_mag(big)
                                               : signed_mag($urandom_range(0, big));
      end else begin
         r.dir_x = corner_dir();
         r.dir_y = corner_dir();
         r.dir_z = corner_dir();
      end
      return r;
   endfunction

   function automatic void add_case(int x, int y, int z, bit typed = 1'b0,
                                    logic [FACE_W-1:0] face = FACE_NONE,
                                    int tx = 0, int ty = 0, bit vr = 1'b0);
      dir_case_type c;
      c.dir.dir_x       = DIR_WIDTH'(x);
      c.dir.dir_y       = DIR_WIDTH'(y);
      c.dir.dir_z       = DIR_WIDTH'(z);
      c.typed           = typed;
      c.want.face       = face;
      c.want.texel_x    = TEX_W'(tx);
      c.want.texel_y    = TEX_W'(ty);
      c.want.valid_res  = vr;
      directed_cases = {directed_cases, c};
   endfunction

   // apb write, bus returned to idle after
   task automatic write_reg(logic reg_idx, logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= {(DATA_W - CFG_W)'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // apb read compared with the register copy
   task automatic check_reg(logic reg_idx, logic [CFG_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata != DATA_W'(want)) begin
         report_mismatch("register readback", want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_face_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      write_reg(REG_FACE_WIDTH, w);
      write_reg(REG_FACE_HEIGHT, h);
      width_reg  = w;
      height_reg = h;
      check_reg(REG_FACE_WIDTH, width_reg);
      check_reg(REG_FACE_HEIGHT, height_reg);
   endtask

   // offer one direction item, expectation queued at acceptance
   task automatic offer_dir(req_type dir, rsp_type want);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= dir;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_texels = {pending_texels, want};
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_phase();
      req_type dir;
      repeat (RANDOM_ITEMS) begin
         dir = random_dir();
         offer_dir(dir, texel_address_of(dir, width_reg, height_reg));
      end
      drain_pipeline();
   endtask

   // result side: random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // in-order result check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (pending_texels.size() == 0) begin
            report_mismatch("result with nothing pending", 0, rsp_data);
         end else begin
            want = pending_texels.pop_front();
            if (rsp_data.face != want.face) begin
               report_mismatch("face", want.face, rsp_data.face);
            end
            if (rsp_data.texel_x != want.texel_x) begin
               report_mismatch("texel_x", want.texel_x, rsp_data.texel_x);
            end
            if (rsp_data.texel_y != want.texel_y) begin
               report_mismatch("texel_y", want.texel_y, rsp_data.texel_y);
            end
            if (rsp_data.valid_res != want.valid_res) begin
               report_mismatch("valid_res", want.valid_res, rsp_data.valid_res);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cubemap_face_texel_address_top regression: fail");
         $finish;
      end
   end

   initial begin
      int w;
      int h;

      // directed items at the reset face size of 512 x 512
      add_case(0, 0, 0, 1'b1, FACE_NONE, 0, 0, 1'b0);
      add_case(-1, 0, 0, 1'b1, FACE_POS_X, 256, 256, 1'b1);
      add_case(1, 0, 0, 1'b1, FACE_NEG_X, 256, 256, 1'b1);
      add_case(0, 1, 0, 1'b1, FACE_POS_Y, 256, 256, 1'b1);
      add_case(0, -1, 0, 1'b1, FACE_NEG_Y, 256, 256, 1'b1);
      add_case(0, 0, 1, 1'b1, FACE_POS_Z, 256, 256, 1'b1);
      add_case(0, 0, -1, 1'b1, FACE_NEG_Z, 256, 256, 1'b1);
      // coordinate of exactly one clamps to the last texel
      add_case(-1, -1, 0, 1'b1, FACE_POS_X, 256, 511, 1'b1);
      // three-way tie goes to x
      add_case(1, 1, 1, 1'b1, FACE_NEG_X, 511, 0, 1'b1);
      // most negative input everywhere
      add_case(-32768, -32768, -32768, 1'b1, FACE_POS_X, 511, 511, 1'b1);
      add_case(0, -32768, 0, 1'b1, FACE_NEG_Y, 256, 256, 1'b1);
      add_case(32767, 32767, 32767);
      add_case(-32767, 0, 32767);
      add_case(32767, -32768, 0);
      add_case(0, 0, -32768);
      add_case(-32768, 32767, -32767);
      add_case(-32768, 0, 0);
      add_case(32767, 0, 0);
      add_case(0, 0, 32767);
      add_case(5, -5, 5);
      add_case(0, 7, -7);
      add_case(3, -9, 9);
      add_case(-1, -1, -1);
      add_case(12345, -222, 30000);
      add_case(-20000, 19999, -20000);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_reg(REG_FACE_WIDTH, width_reg);
      check_reg(REG_FACE_HEIGHT, height_reg);

      foreach (directed_cases[i]) begin
         offer_dir(directed_cases[i].dir,
                   directed_cases[i].typed ? directed_cases[i].want
                   : texel_address_of(directed_cases[i].dir, width_reg, height_reg));
      end
      random_phase();

      // reprogrammed face sizes, extremes first, then random
      for (int p = 0; p < 8; p++) begin
         if (p < 6) begin
            w = PHASE_W[p];
            h = PHASE_H[p];
         end else begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
         end
         set_face_size(CFG_W'(w), CFG_W'(h));
         no_idle = (p == 1);
         random_phase();
      end

      if (mismatch_count == 0) begin
         $display("cubemap_face_texel_address_top regression: pass");
      end else begin
         $display("cubemap_face_texel_address_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== cubemap_face_texel_address_top.f =====
hw/rtl/cmfta_pkg.sv
hw/rtl/cmfta_front.sv
hw/rtl/cmfta_mul.sv
hw/rtl/cmfta_div_cell.sv
hw/rtl/cmfta_out.sv
hw/rtl/cubemap_face_texel_address_top.sv
hw/rtl/cmfta_checker.sv
dv/tb_cubemap_face_texel_address_top.sv
